// File: sv/kirf_pkg.sv
// kirf_pkg: shared constants, types and register codes of the key image report framer
// used by the interfaces, every rtl module and the checker
`default_nettype none

package kirf_pkg;

   // report geometry
   localparam int REPORT_BYTES     = 1024;
   localparam int HEADER_BYTES     = 8;
   localparam int LANES            = 8;
   localparam int LANE_W           = 64;
   localparam int BEAT_BYTES       = LANES * 8;
   localparam int BEATS_PER_REPORT = REPORT_BYTES / BEAT_BYTES;
   localparam int PAYLOAD_BYTES    = REPORT_BYTES - HEADER_BYTES;
   localparam int PAYLOAD_WORDS    = PAYLOAD_BYTES / 8;

   // counter and field widths
   localparam int BEAT_W        = (BEATS_PER_REPORT > 1) ? $clog2(BEATS_PER_REPORT) : 1;
   localparam int WORDS_W       = $clog2(PAYLOAD_WORDS + 1);
   localparam int SLOT_W        = 3;
   localparam int REPORT_NUM_W  = 7;
   localparam int DONE_W        = REPORT_NUM_W + $clog2(PAYLOAD_BYTES + 1);
   localparam int KEY_COLUMN_W  = 3;
   localparam int KEY_ROW_W     = 2;
   localparam int KEY_INDEX_W   = 6;
   localparam int LENGTH_W      = 16;
   localparam int WORD_BYTES_W  = 4;
   localparam int KEY_COLUMNS_W = 4;
   localparam int KEY_ROWS_W    = 3;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 4;

   // header bytes
   localparam logic [7:0] HDR_REPORT_ID = 8'h02;
   localparam logic [7:0] HDR_COMMAND   = 8'h07;
   localparam logic [7:0] HDR_LAST      = 8'h01;
   localparam logic [7:0] HDR_NOT_LAST  = 8'h00;

   // register reset values
   localparam logic [KEY_COLUMNS_W-1:0] KEY_COLUMNS_RESET = 4'd5;
   localparam logic [KEY_ROWS_W-1:0]    KEY_ROWS_RESET    = 3'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_COLUMNS = 1'b0,
      CSR_KEY_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KEY_COLUMNS_W-1:0] key_columns;
      logic [KEY_ROWS_W-1:0]    key_rows;
   } csr_type;

   typedef logic [LANE_W-1:0] lane_type;

   // one in-grid word after masking, ready for framing
   typedef struct packed {
      logic [KEY_INDEX_W-1:0] key_index;
      logic [LENGTH_W-1:0]    image_size;
      lane_type               payload_word;
      logic                   last_word;
   } item_type;

   typedef struct packed {
      lane_type [LANES-1:0] lanes;
      logic [BEAT_W-1:0]    beat_number;
      logic                 report_end;
      logic                 image_end;
   } beat_type;

endpackage

`default_nettype wire

// File: sv/kirf_req_if.sv
// kirf_req_if: input word channel of the key image report framer
// depends on kirf_pkg for field widths
`default_nettype none

interface kirf_req_if;
   import kirf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KEY_COLUMN_W-1:0]   key_column;
   logic [KEY_ROW_W-1:0]      key_row;
   logic [LENGTH_W-1:0]       image_size;
   logic [LANE_W-1:0]         payload_word;
   logic [WORD_BYTES_W-1:0]   word_bytes;
   logic                      last_word;

   modport source (
      output valid, key_column, key_row, image_size, payload_word, word_bytes, last_word,
      input  ready
   );

   modport sink (
      input  valid, key_column, key_row, image_size, payload_word, word_bytes, last_word,
      output ready
   );

endinterface

`default_nettype wire

// File: sv/kirf_rsp_if.sv
// kirf_rsp_if: output beat channel of the key image report framer
// depends on kirf_pkg for lane and beat widths
`default_nettype none

interface kirf_rsp_if;
   import kirf_pkg::*;

   logic              valid;
   logic              ready;
   logic [LANE_W-1:0] lane0;
   logic [LANE_W-1:0] lane1;
   logic [LANE_W-1:0] lane2;
   logic [LANE_W-1:0] lane3;
   logic [LANE_W-1:0] lane4;
   logic [LANE_W-1:0] lane5;
   logic [LANE_W-1:0] lane6;
   logic [LANE_W-1:0] lane7;
   logic [BEAT_W-1:0] beat_number;
   logic              report_end;
   logic              image_end;

   modport source (
      output valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
             beat_number, report_end, image_end,
      input  ready
   );

   modport sink (
      input  valid, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
             beat_number, report_end, image_end,
      output ready
   );

endinterface

`default_nettype wire

// File: sv/key_image_report_framer.sv
// key_image_report_framer: top level, wires the register port, input stage and framer
// depends on kirf_pkg, kirf_req_if, kirf_rsp_if, kirf_csr, kirf_in_stage, kirf_framer
`default_nettype none

// Takes one 64-bit payload word per cycle and frames it into reports of 1024 bytes, sent as
// 16 beats of eight 64-bit lanes; report word 0 is the 8-byte header (0x02, 0x07, key index,
// last flag, chunk length, report index). A beat is offered once the word completing it
// has passed the input register, then the framer's output register. Words are taken back
// to back while the output side keeps up. A word carrying last_word that ends a report
// early makes the framer emit that report's remaining zero beats (up to 15), one per cycle
// while the output keeps up, through the single output register, and holds input meanwhile.
// Words for keys outside the configured grid are dropped without effect. Write key_columns
// and key_rows only while idle; the block does not enforce it. No clearing pass after reset.
module key_image_report_framer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   kirf_req_if.sink                              req_chan,
   kirf_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_enable,
   input  wire logic [kirf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [kirf_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import kirf_pkg::*;

   csr_type  cfg;
   logic     item_valid;
   logic     item_ready;
   item_type item;
   beat_type beat;

   // key grid registers
   kirf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // input register with grid check and word masking
   kirf_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .key_column   (req_chan.key_column),
      .key_row      (req_chan.key_row),
      .image_size   (req_chan.image_size),
      .payload_word (req_chan.payload_word),
      .word_bytes   (req_chan.word_bytes),
      .last_word    (req_chan.last_word),
      .item_valid   (item_valid),
      .item         (item),
      .item_ready   (item_ready)
   );

   // report framing and output beat register
   kirf_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .beat_valid (rsp_chan.valid),
      .beat       (beat),
      .beat_ready (rsp_chan.ready)
   );

   assign rsp_chan.lane0       = beat.lanes[0];
   assign rsp_chan.lane1       = beat.lanes[1];
   assign rsp_chan.lane2       = beat.lanes[2];
   assign rsp_chan.lane3       = beat.lanes[3];
   assign rsp_chan.lane4       = beat.lanes[4];
   assign rsp_chan.lane5       = beat.lanes[5];
   assign rsp_chan.lane6       = beat.lanes[6];
   assign rsp_chan.lane7       = beat.lanes[7];
   assign rsp_chan.beat_number = beat.beat_number;
   assign rsp_chan.report_end  = beat.report_end;
   assign rsp_chan.image_end   = beat.image_end;

endmodule

`default_nettype wire

// File: sv/kirf_csr.sv
// kirf_csr: key grid registers of the framer, written through a plain write port
// depends on kirf_pkg
`default_nettype none

module kirf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [kirf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [kirf_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output kirf_pkg::csr_type                     cfg
);
   import kirf_pkg::*;

   csr_type cfg_ff;
   csr_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_COLUMNS: cfg_in.key_columns = csr_write_data[KEY_COLUMNS_W-1:0];
            CSR_KEY_ROWS:    cfg_in.key_rows    = csr_write_data[KEY_ROWS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_columns <= KEY_COLUMNS_RESET;
         cfg_ff.key_rows    <= KEY_ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/kirf_in_stage.sv
// kirf_in_stage: input register; drops words for keys outside the grid, masks
// partial words and forms the key index. depends on kirf_pkg
`default_nettype none

module kirf_in_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire kirf_pkg::csr_type                 cfg,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [kirf_pkg::KEY_COLUMN_W-1:0] key_column,
   input  wire logic [kirf_pkg::KEY_ROW_W-1:0]    key_row,
   input  wire logic [kirf_pkg::LENGTH_W-1:0]     image_size,
   input  wire logic [kirf_pkg::LANE_W-1:0]       payload_word,
   input  wire logic [kirf_pkg::WORD_BYTES_W-1:0] word_bytes,
   input  wire logic                              last_word,
   output logic                                   item_valid,
   output kirf_pkg::item_type                     item,
   input  wire logic                              item_ready
);
   import kirf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;
   logic     in_grid;
   lane_type masked_word;

   assign req_ready = !valid_ff || item_ready;
   assign accept    = req_valid && req_ready;

   // bounds check against the key grid
   assign in_grid = ({1'b0, key_column} < cfg.key_columns) &&
                    ({1'b0, key_row} < cfg.key_rows);

   // keep only the valid low bytes of a partial word
   always_comb begin
      for (int i = 0; i < LANE_W / 8; i++) begin
         masked_word[i*8 +: 8] = (word_bytes > WORD_BYTES_W'(i)) ? payload_word[i*8 +: 8]
                                                                 : 8'h00;
      end
   end

   // key index is column plus row times columns
   always_comb begin
      item_in.key_index    = KEY_INDEX_W'(key_column) +
                             KEY_INDEX_W'(key_row) * KEY_INDEX_W'(cfg.key_columns);
      item_in.image_size   = image_size;
      item_in.payload_word = masked_word;
      item_in.last_word    = last_word;
   end

   always_comb begin
      priority if (accept) valid_in = in_grid;
      else if (item_ready) valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: sv/kirf_framer.sv
// kirf_framer: beat buffer, report counters, header builder and output beat register
// depends on kirf_pkg
`default_nettype none

module kirf_framer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire kirf_pkg::item_type item,
   output logic                    item_ready,
   output logic                    beat_valid,
   output kirf_pkg::beat_type      beat,
   input  wire logic               beat_ready
);
   import kirf_pkg::*;

   lane_type [LANES-1:0]    buf_ff, buf_in;
   logic [SLOT_W-1:0]       wib_ff, wib_in;
   logic [BEAT_W-1:0]       bir_ff, bir_in;
   logic [WORDS_W-1:0]      words_ff, words_in;
   logic [REPORT_NUM_W-1:0] rnum_ff, rnum_in;
   logic                    pad_ff, pad_in;
   logic                    pad_img_ff, pad_img_in;
   logic                    out_valid_ff, out_valid_in;
   beat_type                out_ff, out_in;

   logic                    can_load;
   logic                    take;
   logic                    start;
   logic                    rep_end_now;
   logic [SLOT_W-1:0]       slot;
   logic [SLOT_W:0]         fill_next;
   logic [WORDS_W-1:0]      words_next;
   logic                    full_beat;
   logic                    report_full;
   lane_type [LANES-1:0]    merged;
   logic [DONE_W-1:0]       done;
   logic [DONE_W-1:0]       len_ext;
   logic [DONE_W-1:0]       rem;
   logic [15:0]             chunk;
   logic [7:0]              last_flag;
   lane_type                header;

   assign can_load   = !out_valid_ff || beat_ready;
   assign item_ready = !pad_ff && can_load;
   assign take       = item_valid && item_ready;

   assign start       = (words_ff == '0) && (wib_ff == '0) && (bir_ff == '0);
   assign rep_end_now = (bir_ff == BEAT_W'(BEATS_PER_REPORT - 1));

   // header: chunk length and last flag follow from image length and report number
   always_comb begin
      done      = DONE_W'(rnum_ff) * DONE_W'(PAYLOAD_BYTES);
      len_ext   = DONE_W'(item.image_size);
      rem       = (len_ext > done) ? (len_ext - done) : '0;
      chunk     = (rem < DONE_W'(PAYLOAD_BYTES)) ? rem[15:0] : 16'(PAYLOAD_BYTES);
      last_flag = (rem <= DONE_W'(PAYLOAD_BYTES)) ? HDR_LAST : HDR_NOT_LAST;
      header    = {16'(rnum_ff), chunk, last_flag, 8'(item.key_index),
                   HDR_COMMAND, HDR_REPORT_ID};
   end

   // place the word in the beat buffer, header first when a report opens
   always_comb begin
      slot   = start ? SLOT_W'(1) : wib_ff;
      merged = buf_ff;
      if (start) begin
         merged[0] = header;
      end
      merged[slot] = item.payload_word;
   end

   assign fill_next   = {1'b0, slot} + (SLOT_W + 1)'(1);
   assign full_beat   = fill_next[SLOT_W];
   assign words_next  = words_ff + WORDS_W'(1);
   assign report_full = (words_next >= WORDS_W'(PAYLOAD_WORDS));

   // next state
   always_comb begin
      buf_in       = buf_ff;
      wib_in       = wib_ff;
      bir_in       = bir_ff;
      words_in     = words_ff;
      rnum_in      = rnum_ff;
      pad_in       = pad_ff;
      pad_img_in   = pad_img_ff;
      out_valid_in = out_valid_ff && !beat_ready;
      out_in       = out_ff;

      priority if (pad_ff) begin
         // zero beats that close a report cut short
         if (can_load) begin
            out_valid_in       = 1'b1;
            out_in.lanes       = '0;
            out_in.beat_number = bir_ff;
            out_in.report_end  = rep_end_now;
            out_in.image_end   = rep_end_now && pad_img_ff;
            if (rep_end_now) begin
               pad_in = 1'b0;
               bir_in = '0;
            end else begin
               bir_in = bir_ff + BEAT_W'(1);
            end
         end
      end else if (take) begin
         if (item.last_word || report_full || full_beat) begin
            out_valid_in       = 1'b1;
            out_in.lanes       = merged;
            out_in.beat_number = bir_ff;
            out_in.report_end  = rep_end_now;
            out_in.image_end   = rep_end_now && item.last_word;
            buf_in             = '0;
            wib_in             = '0;
            if (item.last_word || report_full) begin
               words_in   = '0;
               rnum_in    = item.last_word ? '0 : rnum_ff + REPORT_NUM_W'(1);
               pad_img_in = item.last_word;
               if (rep_end_now) begin
                  bir_in = '0;
               end else begin
                  bir_in = bir_ff + BEAT_W'(1);
                  pad_in = 1'b1;
               end
            end else begin
               bir_in   = bir_ff + BEAT_W'(1);
               words_in = words_next;
            end
         end else begin
            buf_in   = merged;
            wib_in   = fill_next[SLOT_W-1:0];
            words_in = words_next;
         end
      end else begin
         // idle cycle, state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         wib_ff       <= '0;
         bir_ff       <= '0;
         words_ff     <= '0;
         rnum_ff      <= '0;
         pad_ff       <= 1'b0;
         pad_img_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         wib_ff       <= wib_in;
         bir_ff       <= bir_in;
         words_ff     <= words_in;
         rnum_ff      <= rnum_in;
         pad_ff       <= pad_in;
         pad_img_ff   <= pad_img_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output beat payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign beat_valid = out_valid_ff;
   assign beat       = out_ff;

endmodule

`default_nettype wire

// File: sv/kirf_checker.sv
// kirf_checker: port-level assertions on the framer's output beats, and its bind
// depends on kirf_pkg and the key_image_report_framer top level
`default_nettype none

module kirf_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [kirf_pkg::LANE_W-1:0]  lane0,
   input wire logic [kirf_pkg::BEAT_W-1:0]  beat_number,
   input wire logic                         report_end,
   input wire logic                         image_end
);
   import kirf_pkg::*;

   // a stalled beat stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // report end marks exactly the last beat position
   a_report_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (report_end == (beat_number == BEAT_W'(BEATS_PER_REPORT - 1))))
      else $error("report_end does not match beat number");

   // end of image only on a report's last beat
   a_image_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && image_end |-> report_end)
      else $error("image_end without report_end");

   // every report opens with the header id and command bytes
   a_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (beat_number == '0) |-> (lane0[15:0] == {HDR_COMMAND, HDR_REPORT_ID}))
      else $error("first beat lacks header bytes");

   // nothing offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind key_image_report_framer kirf_checker u_kirf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .lane0       (rsp_chan.lane0),
   .beat_number (rsp_chan.beat_number),
   .report_end  (rsp_chan.report_end),
   .image_end   (rsp_chan.image_end)
);

`default_nettype wire

// File: bench/key_image_report_framer_tb.sv
// key_image_report_framer_tb: self-checking bench for the key image report framer
// predicts every 64-byte beat from the words it sends; needs kirf_pkg, kirf_req_if,
// kirf_rsp_if and key_image_report_framer
`timescale 1ns / 1ps

module key_image_report_framer_tb;
   import kirf_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_WORDS  = 100;

   // one directed word; head and body are the typed lanes 0 and 1 of its first beat
   typedef struct packed {
      logic [KEY_COLUMN_W-1:0] col;
      logic [KEY_ROW_W-1:0]    row;
      logic [LENGTH_W-1:0]     len;
      lane_type                data;
      logic [WORD_BYTES_W-1:0] nbytes;
      logic                    last;
      logic                    typed;
      lane_type                head;
      lane_type                body;
   } directed_row_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   csr_index_type            csr_index;
   logic [CSR_DATA_W-1:0]    csr_write_data;

   kirf_req_if req_bus ();
   kirf_rsp_if rsp_bus ();

   key_image_report_framer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // framing state of the predictor
   logic [KEY_COLUMNS_W-1:0] grid_columns = KEY_COLUMNS_RESET;
   logic [KEY_ROWS_W-1:0]    grid_rows    = KEY_ROWS_RESET;
   lane_type                 beat_lanes [LANES];
   int                       lane_slot;
   int                       beat_pos;
   int                       payload_count;
   logic [REPORT_NUM_W-1:0]  report_idx;

   beat_type                 beats_due [$];
   directed_row_type         directed_rows [$];
   int                       mismatch_count;
   int                       cycle_count;
   int                       phase_words;
   int                       burst_left;
   int                       holds_asked;
   int                       holds_served;
   int                       hold_left;
   int                       stall_mode;
   int                       mode_left;
   logic [7:0]               stall_pattern;

   always #2 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic lane_type report_header(int unsigned key, logic [LENGTH_W-1:0] len);
      int unsigned framed;
      int unsigned remaining;
      int unsigned chunk;
      logic [7:0]  last_flag;
      framed    = report_idx * PAYLOAD_BYTES;
      remaining = (len > framed) ? len - framed : 0;
      chunk     = (remaining < PAYLOAD_BYTES) ? remaining : PAYLOAD_BYTES;
      last_flag = (remaining <= PAYLOAD_BYTES) ? HDR_LAST : HDR_NOT_LAST;
      return {9'd0, report_idx, chunk[15:0], last_flag, key[7:0], HDR_COMMAND, HDR_REPORT_ID};
   endfunction

   task automatic push_beat(input logic image_done);
      beat_type b;
      int       i;
      for (i = 0; i < LANES; i++) begin
         b.lanes[i]   = beat_lanes[i];
         beat_lanes[i] = '0;
      end
      b.beat_number = BEAT_W'(beat_pos);
      b.report_end  = (beat_pos + 1 >= BEATS_PER_REPORT);
      b.image_end   = b.report_end && image_done;
      beats_due.push_back(b);
      lane_slot = 0;
      beat_pos++;
   endtask

   // pad out the current report with zero beats
   task automatic close_report(input logic image_done);
      do
         push_beat(image_done);
      while (beat_pos < BEATS_PER_REPORT);
      beat_pos      = 0;
      payload_count = 0;
   endtask

   task automatic frame_word(input logic [KEY_COLUMN_W-1:0] col, input logic [KEY_ROW_W-1:0] row,
                             input logic [LENGTH_W-1:0] len, input lane_type data,
                             input logic [WORD_BYTES_W-1:0] nbytes, input logic last);
      int unsigned used;
      int unsigned key;
      lane_type    w;
      if (col >= grid_columns || row >= grid_rows)
         return;
      used = (nbytes > 8) ? 8 : nbytes;
      w    = data;
      if (used == 0)
         w = '0;
      else if (used < 8)
         w = data & ((64'd1 << (used * 8)) - 64'd1);
      // first word of a report carries the header in slot 0
      if (payload_count == 0 && lane_slot == 0 && beat_pos == 0) begin
         key           = col + row * grid_columns;
         beat_lanes[0] = report_header(key, len);
         lane_slot     = 1;
      end
      beat_lanes[lane_slot] = w;
      lane_slot++;
      payload_count++;
      if (last) begin
         close_report(1'b1);
         report_idx = '0;
      end else if (payload_count >= PAYLOAD_WORDS) begin
         close_report(1'b0);
         report_idx = report_idx + REPORT_NUM_W'(1);
      end else if (lane_slot >= LANES) begin
         push_beat(1'b0);
      end
   endtask

   // ---------------------------------------------------------------- result side

   task automatic flag_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", text);
   endtask

   task automatic check_beat(input beat_type got);
      beat_type want;
      int       i;
      if (beats_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected beat %0d at cycle %0d", got.beat_number,
                                 cycle_count));
         return;
      end
      want = beats_due.pop_front();
      for (i = 0; i < LANES; i++)
         if (got.lanes[i] !== want.lanes[i])
            flag_mismatch($sformatf("beat %0d lane%0d: expected %h, got %h", want.beat_number,
                                    i, want.lanes[i], got.lanes[i]));
      if (got.beat_number !== want.beat_number)
         flag_mismatch($sformatf("beat_number: expected %0d, got %0d", want.beat_number,
                                 got.beat_number));
      if (got.report_end !== want.report_end)
         flag_mismatch($sformatf("beat %0d report_end: expected %b, got %b", want.beat_number,
                                 want.report_end, got.report_end));
      if (got.image_end !== want.image_end)
         flag_mismatch($sformatf("beat %0d image_end: expected %b, got %b", want.beat_number,
                                 want.image_end, got.image_end));
   endtask

   // take beats, then pick ready for the next edge: long hold-off first, else the stall mode
   always @(posedge clock) begin
      beat_type got;
      if (rsp_bus.valid && rsp_bus.ready) begin
         got.lanes       = {rsp_bus.lane7, rsp_bus.lane6, rsp_bus.lane5, rsp_bus.lane4,
                            rsp_bus.lane3, rsp_bus.lane2, rsp_bus.lane1, rsp_bus.lane0};
         got.beat_number = rsp_bus.beat_number;
         got.report_end  = rsp_bus.report_end;
         got.image_end   = rsp_bus.image_end;
         check_beat(got);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served < holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode    = $urandom_range(0, 3);
            mode_left     = $urandom_range(20, 120);
            stall_pattern = 8'($urandom);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= 1'($urandom_range(0, 1));
            default: rsp_bus.ready <= stall_pattern[cycle_count % 8];
         endcase
      end
   end

   // ---------------------------------------------------------------- input side

   // offer one word in bursts with random gaps; returns at the edge that takes it
   task automatic offer_word(input logic [KEY_COLUMN_W-1:0] col, input logic [KEY_ROW_W-1:0] row,
                             input logic [LENGTH_W-1:0] len, input lane_type data,
                             input logic [WORD_BYTES_W-1:0] nbytes, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid        <= 1'b1;
      req_bus.key_column   <= col;
      req_bus.key_row      <= row;
      req_bus.image_size   <= len;
      req_bus.payload_word <= data;
      req_bus.word_bytes   <= nbytes;
      req_bus.last_word    <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_word(input logic [KEY_COLUMN_W-1:0] col, input logic [KEY_ROW_W-1:0] row,
                            input logic [LENGTH_W-1:0] len, input lane_type data,
                            input logic [WORD_BYTES_W-1:0] nbytes, input logic last);
      offer_word(col, row, len, data, nbytes, last);
      if (col < grid_columns && row < grid_rows)
         phase_words++;
      frame_word(col, row, len, data, nbytes, last);
   endtask

   // a word for a key outside the grid, if the grid leaves room for one
   task automatic send_stray();
      logic [KEY_COLUMN_W-1:0] col;
      logic [KEY_ROW_W-1:0]    row;
      if (grid_columns >= 8 && grid_rows >= 4)
         return;
      col = KEY_COLUMN_W'($urandom);
      row = KEY_ROW_W'($urandom);
      if (grid_columns < 8 && (grid_rows >= 4 || $urandom_range(0, 1)))
         col = KEY_COLUMN_W'($urandom_range(grid_columns, 7));
      else
         row = KEY_ROW_W'($urandom_range(grid_rows, 3));
      send_word(col, row, LENGTH_W'($urandom), {$urandom, $urandom},
                WORD_BYTES_W'($urandom), 1'($urandom));
   endtask

   // one image: mostly well formed, sometimes with wrong lengths, odd byte counts,
   // key changes or no closing word; cut short once the phase has its words
   task automatic send_image();
      int                      kind;
      int                      nwords;
      int                      w;
      logic                    broken;
      logic                    closes;
      logic                    last;
      logic [KEY_COLUMN_W-1:0] col;
      logic [KEY_ROW_W-1:0]    row;
      logic [LENGTH_W-1:0]     len;
      logic [WORD_BYTES_W-1:0] nbytes;
      kind   = $urandom_range(0, 9);
      col    = KEY_COLUMN_W'($urandom_range(0, grid_columns - 1));
      row    = KEY_ROW_W'($urandom_range(0, grid_rows - 1));
      broken = (kind >= 8);
      if (kind <= 2)
         len = LENGTH_W'($urandom_range(1, 64));
      else if (kind <= 4)
         len = LENGTH_W'($urandom_range(65, PAYLOAD_BYTES));
      else if (kind <= 7)
         len = LENGTH_W'($urandom_range(PAYLOAD_BYTES + 1, 2100));
      else
         len = LENGTH_W'($urandom);
      nwords = broken ? $urandom_range(1, 260) : (len + 7) / 8;
      closes = !broken || ($urandom_range(0, 3) != 0);
      for (w = 0; w < nwords && phase_words < PHASE_WORDS; w++) begin
         if ($urandom_range(0, 7) == 0)
            send_stray();
         nbytes = 8;
         last   = 1'b0;
         if (w == nwords - 1) begin
            last = closes;
            if (!broken && len % 8 != 0)
               nbytes = WORD_BYTES_W'(len % 8);
         end
         if (broken) begin
            if ($urandom_range(0, 5) == 0)
               nbytes = WORD_BYTES_W'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0) begin
               col = KEY_COLUMN_W'($urandom_range(0, grid_columns - 1));
               row = KEY_ROW_W'($urandom_range(0, grid_rows - 1));
            end
            if ($urandom_range(0, 15) == 0)
               len = LENGTH_W'($urandom);
         end
         send_word(col, row, len, {$urandom, $urandom}, nbytes, last);
      end
   endtask

   task automatic add_row(input logic [KEY_COLUMN_W-1:0] col, input logic [KEY_ROW_W-1:0] row,
                          input logic [LENGTH_W-1:0] len, input lane_type data,
                          input logic [WORD_BYTES_W-1:0] nbytes, input logic last,
                          input logic typed, input lane_type head, input lane_type body);
      directed_rows.push_back({col, row, len, data, nbytes, last, typed, head, body});
   endtask

   // stop sending and wait until every beat is in and the block has gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input logic [KEY_COLUMNS_W-1:0] columns,
                           input logic [KEY_ROWS_W-1:0] rows);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_KEY_COLUMNS;
      csr_write_data   <= columns;
      @(posedge clock);
      csr_index        <= CSR_KEY_ROWS;
      csr_write_data   <= {1'b0, rows};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      grid_columns = columns;
      grid_rows    = rows;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      directed_row_type r;
      beat_type         b;
      int               due_before;
      int               k;
      int               phase;

      clock                = 1'b0;
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_KEY_COLUMNS;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.key_column   = '0;
      req_bus.key_row      = '0;
      req_bus.image_size   = '0;
      req_bus.payload_word = '0;
      req_bus.word_bytes   = '0;
      req_bus.last_word    = 1'b0;
      rsp_bus.ready        = 1'b0;
      mismatch_count       = 0;
      cycle_count          = 0;
      burst_left           = 0;
      holds_asked          = 0;
      holds_served         = 0;
      hold_left            = 0;
      mode_left            = 0;
      lane_slot            = 0;
      beat_pos             = 0;
      payload_count        = 0;
      report_idx           = '0;
      for (k = 0; k < LANES; k++)
         beat_lanes[k] = '0;

      // directed words, grid at its reset size of 5 x 3
      //      col row len      data                    bytes last typed header lane
      add_row(0, 0, 16'd1,     64'hFFFF_FFFF_FFFF_FFFF, 1,  1, 1, 64'h0000_0001_0100_0702,
              64'h0000_0000_0000_00FF);
      add_row(4, 2, 16'hFFFF,  64'h0123_4567_89AB_CDEF, 8,  1, 1, 64'h0000_03F8_000E_0702,
              64'h0123_4567_89AB_CDEF);
      add_row(5, 0, 16'd8,     64'h1111_1111_1111_1111, 8,  1, 0, '0, '0);
      add_row(0, 3, 16'd8,     64'h2222_2222_2222_2222, 8,  1, 0, '0, '0);
      add_row(7, 3, 16'd8,     64'h3333_3333_3333_3333, 8,  1, 0, '0, '0);
      add_row(2, 1, 16'd8,     64'hFFFF_FFFF_FFFF_FFFF, 0,  1, 1, 64'h0000_0008_0107_0702,
              64'h0);
      add_row(3, 0, 16'd16,    64'hA5A5_A5A5_A5A5_A5A5, 15, 1, 1, 64'h0000_0010_0103_0702,
              64'hA5A5_A5A5_A5A5_A5A5);
      add_row(1, 1, 16'd7,     64'h8877_6655_4433_2211, 7,  1, 1, 64'h0000_0007_0106_0702,
              64'h0077_6655_4433_2211);
      add_row(0, 2, 16'd0,     64'hFEDC_BA98_7654_3210, 8,  1, 1, 64'h0000_0000_010A_0702,
              64'hFEDC_BA98_7654_3210);
      add_row(4, 0, 16'd1016,  64'hDEAD_BEEF_CAFE_F00D, 4,  1, 1, 64'h0000_03F8_0104_0702,
              64'h0000_0000_CAFE_F00D);
      add_row(1, 0, 16'd1017,  64'hFFFF_FFFF_FFFF_FFFF, 3,  1, 1, 64'h0000_03F8_0001_0702,
              64'h0000_0000_00FF_FFFF);
      // nine-word image with a stray word and a key change after it opened
      add_row(3, 2, 16'd70,    64'h1010_1010_1010_1010, 8,  0, 0, '0, '0);
      add_row(3, 2, 16'd70,    64'h2020_2020_2020_2020, 8,  0, 0, '0, '0);
      add_row(6, 0, 16'd70,    64'hEEEE_EEEE_EEEE_EEEE, 8,  1, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h3030_3030_3030_3030, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h4040_4040_4040_4040, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h5050_5050_5050_5050, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h6060_6060_6060_6060, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h7070_7070_7070_7070, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h8080_8080_8080_8080, 8,  0, 0, '0, '0);
      add_row(0, 0, 16'd70,    64'h9090_9090_9090_9090, 6,  1, 0, '0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // typed rows replace lanes 0 and 1 of the first beat they cause
      for (k = 0; k < directed_rows.size(); k++) begin
         r = directed_rows[k];
         offer_word(r.col, r.row, r.len, r.data, r.nbytes, r.last);
         due_before = beats_due.size();
         frame_word(r.col, r.row, r.len, r.data, r.nbytes, r.last);
         if (r.typed && beats_due.size() > due_before) begin
            b                     = beats_due[due_before];
            b.lanes[0]            = r.head;
            b.lanes[1]            = r.body;
            beats_due[due_before] = b;
         end
      end

      // random images over several grid sizes, the extremes among them
      for (phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: set_grid(4'd8, 3'd4);
            1: set_grid(4'd1, 3'd1);
            2: set_grid(KEY_COLUMNS_W'($urandom_range(1, 8)), KEY_ROWS_W'($urandom_range(1, 4)));
            default: set_grid(4'd3, 3'd2);
         endcase
         // receiver backs off for a long stretch while words keep coming
         if (phase % 2 == 0)
            holds_asked++;
         phase_words = 0;
         while (phase_words < PHASE_WORDS)
            send_image();
         // close a stream left open so the next phase starts from report 0
         if (lane_slot != 0 || beat_pos != 0 || payload_count != 0 || report_idx != 0)
            send_word(KEY_COLUMN_W'($urandom_range(0, grid_columns - 1)),
                      KEY_ROW_W'($urandom_range(0, grid_rows - 1)),
                      16'd8, {$urandom, $urandom}, 4'd8, 1'b1);
      end

      settle();
      if (beats_due.size() != 0)
         flag_mismatch($sformatf("%0d beats never arrived", beats_due.size()));
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
